@@ design/flvac_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flvac_pkg
// Shared types, constants and helpers of the FLV AVC to Annex B converter.
// ----------------------------------------------------------------------------
package flvac_pkg;

   localparam int UNIT_LENGTH_BITS = 32;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] CODEC_AVC       = 4'd7;
   localparam logic [7:0] START_CODE_LAST = 8'h01;
   localparam logic [7:0] START_CODE_ZERO = 8'h00;
   localparam logic [3:0] IDX_CODEC       = 4'd0;
   localparam logic [3:0] IDX_PKT_TYPE    = 4'd1;
   localparam logic [3:0] IDX_HEAD_END    = 4'd4;
   localparam logic [3:0] IDX_LEN_SIZE    = 4'd9;
   localparam logic [3:0] IDX_SPS_LEN_HI  = 4'd11;
   localparam logic [3:0] IDX_SPS_LEN_LO  = 4'd12;
   localparam logic [3:0] IDX_MAX         = 4'd15;
   localparam logic [1:0] STEP_LAST       = 2'd3;

   localparam logic [32:0] MAX_LEN = (33'd1 << UNIT_LENGTH_BITS) - 33'd1;

   typedef struct packed {
      logic [7:0] tag_byte;
      logic       tag_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       unit_start;
      logic       run_last;
      logic       truncated;
   } rsp_type;

   // One queued job: a four byte start code or a single payload byte.
   typedef struct packed {
      logic       opens_unit;
      logic [7:0] data;
      logic       trunc;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [UNIT_LENGTH_BITS-1:0] clamp_len(input logic [31:0] v);
      logic [32:0] wide;
      wide = {1'b0, v};
      if (wide > MAX_LEN) begin
         return MAX_LEN[UNIT_LENGTH_BITS-1:0];
      end
      return wide[UNIT_LENGTH_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

@@ design/flvac_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flvac_front
// Parses the tag body one byte at a time and queues the jobs it yields.
// ----------------------------------------------------------------------------
module flvac_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  flvac_pkg::req_type         req_word,
   input  flvac_pkg::queue_status_type q_status,
   output logic                       push,
   output flvac_pkg::job_type         push_job
);
   import flvac_pkg::*;

   typedef enum logic [3:0] {
      PH_HEAD, PH_IGNORE, PH_CFG, PH_SPS, PH_NPPS,
      PH_PPSLEN, PH_PPS, PH_PREFIX, PH_NALU
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [3:0]                  index_ff, index_in;
   logic                        cfg_pkt_ff, cfg_pkt_in;
   logic [2:0]                  psize_ff, psize_in;
   logic [31:0]                 acc_ff, acc_in;
   logic [UNIT_LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [1:0]                  seen_ff, seen_in;

   logic                        fire;
   logic                        do_open, do_pass;
   phase_type                   body_ph, after_ph;
   logic [UNIT_LENGTH_BITS-1:0] len, dec;
   logic [7:0]                  b;
   logic                        last;
   logic [31:0]                 shifted;

   assign req_ready = !q_status.full;
   assign fire      = req_valid && req_ready;
   assign b         = req_word.tag_byte;
   assign last      = req_word.tag_last;
   assign shifted   = {acc_ff[23:0], b};

   always_comb begin
      phase_in   = phase_ff;
      index_in   = (index_ff == IDX_MAX) ? index_ff : index_ff + 4'd1;
      cfg_pkt_in = cfg_pkt_ff;
      psize_in   = psize_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      seen_in    = seen_ff;
      do_open    = 1'b0;
      do_pass    = 1'b0;
      body_ph    = PH_NALU;
      after_ph   = PH_PREFIX;
      push       = 1'b0;
      push_job   = '{opens_unit: 1'b0, data: b, trunc: 1'b0};
      len        = clamp_len(acc_in);
      dec        = rem_ff;

      unique case (phase_ff)
         PH_HEAD: begin
            if (index_ff == IDX_CODEC) begin
               if (b[3:0] != CODEC_AVC) phase_in = PH_IGNORE;
            end else if (index_ff == IDX_PKT_TYPE) begin
               cfg_pkt_in = (b == 8'd0);
            end else if (index_ff >= IDX_HEAD_END) begin
               phase_in = cfg_pkt_ff ? PH_CFG : PH_PREFIX;
            end
         end
         PH_IGNORE: begin
         end
         PH_CFG: begin
            if (index_ff == IDX_LEN_SIZE) begin
               psize_in = {1'b0, b[1:0]} + 3'd1;
            end else if (index_ff == IDX_SPS_LEN_HI) begin
               acc_in = {24'd0, b};
            end else if (index_ff >= IDX_SPS_LEN_LO) begin
               acc_in   = shifted;
               do_open  = 1'b1;
               body_ph  = PH_SPS;
               after_ph = PH_NPPS;
            end
         end
         PH_SPS: begin
            do_pass  = 1'b1;
            after_ph = PH_NPPS;
         end
         PH_NPPS: begin
            seen_in  = 2'd0;
            phase_in = PH_PPSLEN;
         end
         PH_PPSLEN: begin
            if (seen_ff == 2'd0) begin
               acc_in  = {24'd0, b};
               seen_in = 2'd1;
            end else begin
               acc_in   = shifted;
               seen_in  = 2'd0;
               do_open  = 1'b1;
               body_ph  = PH_PPS;
               after_ph = PH_IGNORE;
            end
         end
         PH_PPS: begin
            do_pass  = 1'b1;
            after_ph = PH_IGNORE;
         end
         PH_PREFIX: begin
            acc_in = (seen_ff == 2'd0) ? {24'd0, b} : shifted;
            if ({1'b0, seen_ff} + 3'd1 >= psize_ff) begin
               seen_in = 2'd0;
               do_open = 1'b1;
            end else begin
               seen_in = seen_ff + 2'd1;
            end
         end
         PH_NALU: begin
            do_pass = 1'b1;
         end
         default: begin
         end
      endcase

      len = clamp_len(acc_in);
      if (do_open) begin
         push                = 1'b1;
         push_job.opens_unit = 1'b1;
         push_job.trunc      = last && (len != '0);
         rem_in              = len;
         phase_in            = (len == '0) ? after_ph : body_ph;
      end
      if (do_pass) begin
         if (rem_ff != '0) dec = rem_ff - UNIT_LENGTH_BITS'(1);
         push           = 1'b1;
         push_job.trunc = last && (dec != '0);
         rem_in         = dec;
         if (dec == '0) phase_in = after_ph;
      end

      if (last) begin
         phase_in   = PH_HEAD;
         index_in   = '0;
         cfg_pkt_in = 1'b0;
         acc_in     = '0;
         rem_in     = '0;
         seen_in    = '0;
      end
      push = push && fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEAD;
         index_ff   <= '0;
         cfg_pkt_ff <= 1'b0;
         psize_ff   <= 3'd4;
         acc_ff     <= '0;
         rem_ff     <= '0;
         seen_ff    <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         cfg_pkt_ff <= cfg_pkt_in;
         psize_ff   <= psize_in;
         acc_ff     <= acc_in;
         rem_ff     <= rem_in;
         seen_ff    <= seen_in;
      end
   end

endmodule
`default_nettype wire

@@ design/flvac_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flvac_queue
// Short job queue that lets the parser and the emitter stall separately.
// ----------------------------------------------------------------------------
module flvac_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  flvac_pkg::job_type          push_job,
   input  wire                         pop,
   output flvac_pkg::job_type          head_job,
   output flvac_pkg::queue_status_type q_status
);
   import flvac_pkg::*;

   job_type                   slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic                      do_push, do_pop;

   assign q_status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + QUEUE_CNT_BITS'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - QUEUE_CNT_BITS'(1);
      end
   end

endmodule
`default_nettype wire

@@ design/flvac_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flvac_back
// Expands queued jobs into output words and holds them for the receiver.
// ----------------------------------------------------------------------------
module flvac_back (
   input  wire                         clock,
   input  wire                         reset,
   input  flvac_pkg::job_type          head_job,
   input  flvac_pkg::queue_status_type q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output flvac_pkg::rsp_type          rsp_word
);
   import flvac_pkg::*;

   logic    valid_ff;
   job_type job_ff;
   logic [1:0] step_ff;
   logic    advance, more_steps, end_of_job;

   assign advance    = !valid_ff || rsp_ready;
   assign more_steps = valid_ff && job_ff.opens_unit && (step_ff != STEP_LAST);
   assign pop        = advance && !more_steps && !q_status.empty;
   assign end_of_job = !job_ff.opens_unit || (step_ff == STEP_LAST);

   assign rsp_valid           = valid_ff;
   assign rsp_word.out_byte   = !job_ff.opens_unit ? job_ff.data :
                                (step_ff == STEP_LAST) ? START_CODE_LAST : START_CODE_ZERO;
   assign rsp_word.unit_start = job_ff.opens_unit && (step_ff == 2'd0);
   assign rsp_word.run_last   = end_of_job;
   assign rsp_word.truncated  = job_ff.trunc && end_of_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else if (advance) begin
         if (more_steps) begin
            step_ff <= step_ff + 2'd1;
         end else if (!q_status.empty) begin
            valid_ff <= 1'b1;
            step_ff  <= '0;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) job_ff <= head_job;
   end

endmodule
`default_nettype wire

@@ design/flv_avc_to_annexb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flv_avc_to_annexb
// Converts FLV AVC video tag bodies into an H.264 Annex B byte stream.
// ----------------------------------------------------------------------------
// The req channel takes one tag body byte per word, with tag_last on the
// final byte of each tag. The rsp channel gives one stream byte per word.
// A byte that completes a length prefix yields a four word start code, a
// payload byte yields one word, and header bytes yield nothing.
// The parser accepts one byte per cycle while the job queue has room. The
// emitter sends one word per cycle while the receiver is ready, so payload
// runs at one byte per cycle and each start code takes four words.
// The first word of a byte is written into the queue and then loaded into
// the emitter register before it is offered to the receiver.
// When the receiver stalls, the current word holds and the two entry queue
// absorbs two more jobs before req_ready falls.
// Reset empties the queue, returns the parser to the tag header and sets
// the length prefix size to four bytes.
// ----------------------------------------------------------------------------
module flv_avc_to_annexb (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  flvac_pkg::req_type req_word,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output flvac_pkg::rsp_type rsp_word
);
   import flvac_pkg::*;

   queue_status_type q_status;
   job_type          push_job, head_job;
   logic             push, pop;

   flvac_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   flvac_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head_job(head_job),
      .q_status(q_status)
   );

   flvac_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

endmodule
`default_nettype wire

@@ design/flvac_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flvac_checker
// Port level checks of the converter, bound to its top level.
// ----------------------------------------------------------------------------
module flvac_checker (
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input flvac_pkg::rsp_type rsp_word
);
   import flvac_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.unit_start |-> rsp_word.out_byte == START_CODE_ZERO
      && !rsp_word.run_last)
      else $error("start code word malformed");

   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.truncated |-> rsp_word.run_last)
      else $error("truncated word is not the last of its run");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind flv_avc_to_annexb flvac_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_word (rsp_word)
);
`default_nettype wire

@@ test/annexb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_checker
// Watches both channels of the FLV AVC to Annex B converter, works out the
// stream words that each accepted tag byte should produce, and compares every
// word that leaves the block against the oldest word still expected.
// ----------------------------------------------------------------------------
module annexb_checker #(
   parameter logic [7:0] SEQ_HEADER_TYPE = 8'h00
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  flvac_pkg::req_type req_word,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  flvac_pkg::rsp_type rsp_word,
   output int unsigned        fail_count,
   output int unsigned        outstanding,
   output int unsigned        words_checked,
   output int unsigned        truncated_seen
);
   import flvac_pkg::*;

   localparam logic [2:0] DEFAULT_PREFIX_LEN = 3'd4;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_SKIP,
      PH_CONFIG,
      PH_SPS_BODY,
      PH_PPS_COUNT,
      PH_PPS_LENGTH,
      PH_PPS_BODY,
      PH_LENGTH,
      PH_PAYLOAD
   } conv_phase_type;

   conv_phase_type conv_phase;
   logic [23:0]    tag_index;
   logic           is_avc;
   logic           is_seq_header;
   logic [2:0]     prefix_len;
   logic [31:0]    length_acc;
   logic [31:0]    remaining;
   logic [1:0]     prefix_seen;

   rsp_type        burst [4];
   int             burst_n;
   rsp_type        expected_words [$];
   int unsigned    failures;
   int unsigned    words_seen;
   int unsigned    trunc_words;

   assign fail_count     = failures;
   assign words_checked  = words_seen;
   assign truncated_seen = trunc_words;

   task automatic clear_tag_state();
      conv_phase    = PH_HEADER;
      tag_index     = '0;
      is_avc        = 1'b0;
      is_seq_header = 1'b0;
      length_acc    = '0;
      remaining     = '0;
      prefix_seen   = '0;
   endtask

   task automatic add_word(input logic [7:0] b, input logic first, input logic cut);
      rsp_type w;
      w.out_byte   = b;
      w.unit_start = first;
      w.run_last   = 1'b0;
      w.truncated  = cut;
      burst[burst_n] = w;
      burst_n++;
   endtask

   task automatic start_unit(input logic [31:0] len, input conv_phase_type body,
                             input conv_phase_type after, input logic last);
      logic [32:0] ceiling;
      logic [31:0] unit_len;
      ceiling  = (33'd1 << UNIT_LENGTH_BITS) - 33'd1;
      unit_len = ({1'b0, len} > ceiling) ? ceiling[31:0] : len;
      add_word(START_CODE_ZERO, 1'b1, 1'b0);
      add_word(START_CODE_ZERO, 1'b0, 1'b0);
      add_word(START_CODE_ZERO, 1'b0, 1'b0);
      add_word(START_CODE_LAST, 1'b0, last && unit_len != 0);
      remaining  = unit_len;
      conv_phase = (unit_len == 0) ? after : body;
   endtask

   task automatic pass_payload(input logic [7:0] b, input conv_phase_type after,
                               input logic last);
      if (remaining != 0) remaining--;
      add_word(b, 1'b0, last && remaining != 0);
      if (remaining == 0) conv_phase = after;
   endtask

   task automatic predict_annexb(input logic [7:0] b, input logic last);
      logic [23:0] idx;
      rsp_type     w;
      int          i;
      idx     = tag_index;
      burst_n = 0;
      case (conv_phase)
         PH_HEADER: begin
            if (idx == IDX_CODEC) begin
               is_avc = (b[3:0] == CODEC_AVC);
               if (!is_avc) conv_phase = PH_SKIP;
            end else if (idx == IDX_PKT_TYPE) begin
               is_seq_header = (b == SEQ_HEADER_TYPE);
            end else if (idx >= IDX_HEAD_END) begin
               conv_phase = is_seq_header ? PH_CONFIG : PH_LENGTH;
            end
         end
         PH_CONFIG: begin
            if (idx == IDX_LEN_SIZE) begin
               prefix_len = {1'b0, b[1:0]} + 3'd1;
            end else if (idx == IDX_SPS_LEN_HI) begin
               length_acc = {24'd0, b};
            end else if (idx >= IDX_SPS_LEN_LO) begin
               length_acc = {length_acc[23:0], b};
               start_unit(length_acc, PH_SPS_BODY, PH_PPS_COUNT, last);
            end
         end
         PH_SPS_BODY: pass_payload(b, PH_PPS_COUNT, last);
         PH_PPS_COUNT: begin
            prefix_seen = '0;
            conv_phase  = PH_PPS_LENGTH;
         end
         PH_PPS_LENGTH: begin
            if (prefix_seen == 0) begin
               length_acc  = {24'd0, b};
               prefix_seen = 2'd1;
            end else begin
               length_acc  = {length_acc[23:0], b};
               prefix_seen = '0;
               start_unit(length_acc, PH_PPS_BODY, PH_SKIP, last);
            end
         end
         PH_PPS_BODY: pass_payload(b, PH_SKIP, last);
         PH_LENGTH: begin
            length_acc = (prefix_seen == 0) ? {24'd0, b} : {length_acc[23:0], b};
            if ({1'b0, prefix_seen} + 3'd1 >= prefix_len) begin
               prefix_seen = '0;
               start_unit(length_acc, PH_PAYLOAD, PH_LENGTH, last);
            end else begin
               prefix_seen = prefix_seen + 2'd1;
            end
         end
         PH_PAYLOAD: pass_payload(b, PH_LENGTH, last);
         default: begin
         end
      endcase
      if (tag_index != '1) tag_index++;
      if (last) clear_tag_state();
      for (i = 0; i < burst_n; i++) begin
         w = burst[i];
         w.run_last = (i == burst_n - 1);
         expected_words = {expected_words, w};
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_tag_state();
         prefix_len = DEFAULT_PREFIX_LEN;
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_annexb(req_word.tag_byte, req_word.tag_last);
         end
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (rsp_word.truncated) trunc_words++;
            if (expected_words.size() == 0) begin
               if (failures < 10) begin
                  $display("Unexpected word %0d: byte %h start %b last %b trunc %b",
                           words_seen, rsp_word.out_byte, rsp_word.unit_start,
                           rsp_word.run_last, rsp_word.truncated);
               end
               failures++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.out_byte !== want.out_byte ||
                   rsp_word.unit_start !== want.unit_start ||
                   rsp_word.run_last !== want.run_last ||
                   rsp_word.truncated !== want.truncated) begin
                  if (failures < 10) begin
                     $display({"Word %0d: expected byte %h start %b last %b trunc %b,",
                               " got byte %h start %b last %b trunc %b"},
                              words_seen, want.out_byte, want.unit_start, want.run_last,
                              want.truncated, rsp_word.out_byte, rsp_word.unit_start,
                              rsp_word.run_last, rsp_word.truncated);
                  end
                  failures++;
               end
            end
         end
      end
      outstanding <= expected_words.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives FLV video tag bodies into the AVC to Annex B converter: a directed
// set of sequence headers, NAL unit tags, foreign codec tags and cut tags,
// then random tags under several patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import flvac_pkg::*;

   localparam logic [7:0] PKT_SEQ_HEADER = 8'h00;
   localparam logic [7:0] PKT_NALU       = 8'h01;
   localparam int         QUIET_LIMIT    = 2000;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         ITEM_TARGET    = 400;
   localparam int         TAIL_CYCLES    = 20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_word;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_word;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned words_checked;
   int unsigned truncated_seen;

   int          send_idle_pct;
   int          stall_pct;
   int          hold_requests;
   logic [7:0]  tag_body [$];
   logic [2:0]  stream_prefix;
   int unsigned tags_sent;
   int unsigned stream_bytes;
   int unsigned items_sent;

   flv_avc_to_annexb uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   annexb_checker #(.SEQ_HEADER_TYPE(PKT_SEQ_HEADER)) u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .words_checked  (words_checked),
      .truncated_seen (truncated_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic logic [7:0] byte_of(input logic [31:0] value, input int pos);
      logic [31:0] s;
      s = value >> (8 * pos);
      return s[7:0];
   endfunction

   task automatic add_byte(input logic [7:0] b);
      tag_body = {tag_body, b};
   endtask

   task automatic send_word(input logic [7:0] b, input logic last);
      req_type w;
      w.tag_byte = b;
      w.tag_last = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_tag();
      logic [7:0] head;
      logic [7:0] size_byte;
      int         i;
      head = tag_body[0];
      if (tag_body.size() > 9 && head[3:0] == CODEC_AVC && tag_body[1] == PKT_SEQ_HEADER) begin
         size_byte     = tag_body[9];
         stream_prefix = {1'b0, size_byte[1:0]} + 3'd1;
      end
      if (head[3:0] == CODEC_AVC && tag_body.size() > 5) begin
         stream_bytes += tag_body.size() - 5;
      end
      for (i = 0; i < tag_body.size(); i++) begin
         send_word(tag_body[i], i == tag_body.size() - 1);
      end
      tags_sent++;
      items_sent += tag_body.size();
      tag_body.delete();
   endtask

   task automatic cut_tag(input int keep);
      while (tag_body.size() > keep) void'(tag_body.pop_back());
   endtask

   task automatic start_avc_tag(input logic [7:0] pkt_type);
      logic [7:0] r;
      r = rand_byte();
      add_byte({r[7:4], CODEC_AVC});
      add_byte(pkt_type);
      repeat (3) add_byte(rand_byte());
   endtask

   task automatic add_other_tag(input int len);
      logic [7:0] r;
      r = rand_byte();
      while (r[3:0] == CODEC_AVC) r = rand_byte();
      add_byte(r);
      repeat (len - 1) add_byte(rand_byte());
   endtask

   task automatic add_nal_unit(input int unsigned len);
      int i;
      for (i = int'(stream_prefix) - 1; i >= 0; i--) add_byte(byte_of(len, i));
      for (i = 0; i < len; i++) add_byte(rand_byte());
   endtask

   task automatic add_config_tag(input logic [1:0] size_code, input int unsigned sps_len,
                                 input int unsigned pps_len, input int tail);
      logic [7:0] r;
      start_avc_tag(PKT_SEQ_HEADER);
      repeat (4) add_byte(rand_byte());
      r = rand_byte();
      r[1:0] = size_code;
      add_byte(r);
      add_byte(rand_byte());
      add_byte(byte_of(sps_len, 1));
      add_byte(byte_of(sps_len, 0));
      repeat (sps_len) add_byte(rand_byte());
      add_byte(rand_byte());
      add_byte(byte_of(pps_len, 1));
      add_byte(byte_of(pps_len, 0));
      repeat (pps_len) add_byte(rand_byte());
      repeat (tail) add_byte(rand_byte());
   endtask

   task automatic add_random_tag();
      int         pick;
      int         units;
      logic [7:0] pkt_type;
      pick = $urandom_range(99);
      if (pick < 10) begin
         add_config_tag(2'($urandom_range(3)), $urandom_range(12), $urandom_range(6),
                        $urandom_range(3));
      end else if (pick < 80) begin
         pkt_type = 8'($urandom_range(255, 1));
         start_avc_tag(pkt_type);
         units = $urandom_range(4, 1);
         repeat (units) begin
            add_nal_unit(($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12));
         end
      end else if (pick < 90) begin
         add_other_tag($urandom_range(12, 1));
      end else begin
         start_avc_tag(rand_byte());
         repeat ($urandom_range(10)) add_byte(rand_byte());
      end
      if ($urandom_range(4) == 0) cut_tag($urandom_range(tag_body.size(), 1));
      send_tag();
   endtask

   initial begin : receiver
      int served;
      served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int p;
      int unsigned goal;
      int unsigned base;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_word      <= '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests = 0;
      stream_prefix = 3'd4;
      tags_sent     = 0;
      stream_bytes  = 0;
      items_sent    = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A tag from another codec is dropped whole.
      add_other_tag(6);
      send_tag();
      // Four byte prefixes, with bytes after the first PPS that are ignored.
      add_config_tag(2'd3, 3, 2, 2);
      send_tag();
      // An empty unit, a one byte unit and an ordinary unit.
      start_avc_tag(PKT_NALU);
      add_nal_unit(0);
      add_nal_unit(1);
      add_nal_unit(5);
      send_tag();
      // The largest length, with the tag ending after three payload bytes.
      start_avc_tag(PKT_NALU);
      repeat (4) add_byte(8'hFF);
      repeat (3) add_byte(rand_byte());
      send_tag();
      // The tag ends on the byte that completes a nonzero length.
      start_avc_tag(PKT_NALU);
      add_nal_unit(5);
      cut_tag(tag_body.size() - 5);
      send_tag();
      // The tag ends inside a length prefix.
      start_avc_tag(PKT_NALU);
      add_nal_unit(3);
      cut_tag(7);
      send_tag();
      // A sequence header cut before its prefix size byte.
      add_config_tag(2'd0, 2, 2, 0);
      cut_tag(8);
      send_tag();
      // One byte prefixes, with an empty SPS and PPS.
      add_config_tag(2'd0, 0, 0, 0);
      send_tag();
      start_avc_tag(PKT_NALU);
      add_nal_unit(17);
      add_nal_unit(0);
      add_nal_unit(2);
      send_tag();
      // Two byte prefixes, cut inside the SPS.
      add_config_tag(2'd1, 4, 1, 0);
      cut_tag(15);
      send_tag();
      start_avc_tag(rand_byte() | 8'h01);
      add_nal_unit(3);
      add_nal_unit(1);
      send_tag();
      // Three byte prefixes, cut inside the PPS.
      add_config_tag(2'd2, 1, 4, 0);
      cut_tag(19);
      send_tag();
      start_avc_tag(PKT_NALU);
      add_nal_unit(2);
      add_nal_unit(0);
      send_tag();
      // Tags too short to finish their header.
      start_avc_tag(PKT_NALU);
      cut_tag(3);
      send_tag();
      start_avc_tag(PKT_NALU);
      cut_tag(1);
      send_tag();
      add_other_tag(1);
      send_tag();
      // Back to four byte prefixes; the tag ends on the SPS length.
      add_config_tag(2'd3, 6, 1, 0);
      cut_tag(13);
      send_tag();
      // The tag ends on the PPS count.
      add_config_tag(2'd3, 1, 1, 0);
      cut_tag(15);
      send_tag();

      base = items_sent;
      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               hold_requests++;
            end
            1: begin
               send_idle_pct = 88;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 88;
            end
            default: begin
               send_idle_pct = 28;
               stall_pct     = 28;
            end
         endcase
         goal = base + (ITEM_TARGET - base) * (p + 1) / 4;
         while (items_sent < goal) add_random_tag();
      end

      req_valid <= 1'b0;
      stall_pct = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d tags, %0d bytes in all and %0d past the AVC header;",
               tags_sent, items_sent, stream_bytes);
      $display("checked %0d stream words, %0d marked as cut short, with %0d mismatches.",
               words_checked, truncated_seen, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
